[rtl/assert_macros.svh]
// Assertion macros used by the top level of the point attractor block.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PAU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define PAU_ASSERT(label, prop, msg)
`define PAU_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

[rtl/pau_pkg.sv]
// Package of the point attractor update block: widths, codes and constants.
// Depends on nothing.
`timescale 1ns / 1ps
package pau_pkg;

  localparam int unsigned FracBits = 16;   // fraction bits of positions and strength
  localparam int unsigned TimeFrac = 16;   // time step is always Q0.16
  localparam int unsigned ValW     = 32;
  localparam int unsigned MagW     = 32;   // |dx|, |dy|
  localparam int unsigned SqW      = 65;   // dx^2 + dy^2
  localparam int unsigned RootW    = 33;   // floor(sqrt(S))
  localparam int unsigned AW       = 31;   // |strength| * dt
  localparam int unsigned QW       = SqW - FracBits;        // max(1, S) in fixed point
  localparam int unsigned ProdW    = AW + QW;
  localparam int unsigned PW       = ProdW - FracBits;      // pull magnitude
  localparam int unsigned DivNumW  = AW + FracBits;
  localparam int unsigned InDataW  = 144;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [2:0] {
    FallConst   = 3'd0,
    FallLinear  = 3'd1,
    FallInvLin  = 3'd2,
    FallQuad    = 3'd3,
    FallInvQuad = 3'd4
  } falloff_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegStrength = 3'd0,
    RegPointX   = 3'd1,
    RegPointY   = 3'd2,
    RegFalloff  = 3'd3,
    RegTarget   = 3'd4
  } cfg_reg_e;

endpackage

[rtl/point_attractor_update.sv]
// Top level of the point attractor update: config registers and the main pipeline.
// Depends on pau_pkg, pau_isqrt, pau_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Point attractor update. Each input beat carries one particle position, the
// attribute to be pulled and a time step; each output beat carries the
// pulled attribute (saturated Q16.16) and an applied flag that is low when
// strength is zero. The block is a fixed pipeline: one beat enters every
// cycle while the output is not stalled, and passes 3 input stages, a 33-stage
// square root for the distance, 3 stages for the falloff multiply, a
// 47-stage divider for the inverse falloff modes, 3 stages for the
// direction products and a 32-stage divider per axis for p*|d|/r, then the
// output register. The whole pipeline holds while a result waits on
// m_axis_tready; s_axis_tready follows that stall and nothing else.
// Configuration is written through the cfg port; the user must write it only
// while no beat is in flight, which the block itself does not enforce. The
// target attribute register is accepted but changes nothing in the arithmetic, so it is not stored.
module point_attractor_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // particle_x, particle_y, attr_x, attr_y, time_step (lowest bit up)
  input  logic [pau_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // new_attr_x, new_attr_y, applied, zero fill (lowest bit up)
  output logic [pau_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pau_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int unsigned VW = pau_pkg::ValW;
  localparam int unsigned MW = pau_pkg::MagW;
  localparam int unsigned RW = pau_pkg::RootW;
  localparam int unsigned QW = pau_pkg::QW;
  localparam int unsigned AW = pau_pkg::AW;
  localparam int unsigned PW = pau_pkg::PW;
  localparam int unsigned FB = pau_pkg::FracBits;
  localparam int unsigned HiW = QW - 32;

  localparam logic [RW-1:0] OneR = RW'(1) << FB;
  localparam logic [QW-1:0] OneQ = QW'(1) << FB;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [VW-1:0]     strength_q;
  logic [VW-1:0]     point_x_q;
  logic [VW-1:0]     point_y_q;
  pau_pkg::falloff_e falloff_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= '0;
      point_x_q  <= '0;
      point_y_q  <= '0;
      falloff_q  <= pau_pkg::FallLinear;
    end else if (cfg_valid_i) begin
      case (pau_pkg::cfg_reg_e'(cfg_index_i))
        pau_pkg::RegStrength: strength_q <= cfg_data_i;
        pau_pkg::RegPointX:   point_x_q  <= cfg_data_i;
        pau_pkg::RegPointY:   point_y_q  <= cfg_data_i;
        pau_pkg::RegFalloff:  falloff_q  <= pau_pkg::falloff_e'(cfg_data_i[2:0]);
        pau_pkg::RegTarget:   ;  // every target is updated the same way
        default:              ;  // drop writes beyond the register list
      endcase
    end
  end

  // Global advance: the pipeline moves unless a finished result is stuck.
  logic out_vld_q;
  logic pipe_en;

  assign pipe_en       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // ---------------------------------------------------------------------------
  // Stage A: offset to the point, split into magnitude and sign
  // ---------------------------------------------------------------------------
  logic [VW-1:0] in_px, in_py;
  logic [VW:0]   dx, dy;
  logic [MW-1:0] adx, ady;

  assign in_px = s_axis_tdata[31:0];
  assign in_py = s_axis_tdata[63:32];
  assign dx    = {point_x_q[VW-1], point_x_q} - {in_px[VW-1], in_px};
  assign dy    = {point_y_q[VW-1], point_y_q} - {in_py[VW-1], in_py};
  assign adx   = dx[VW] ? MW'(-dx) : dx[MW-1:0];
  assign ady   = dy[VW] ? MW'(-dy) : dy[MW-1:0];

  logic          a_vld_q;
  logic [MW-1:0] a_adx_q, a_ady_q;
  logic          a_dxneg_q, a_dyneg_q;
  logic [VW-1:0] a_ax_q, a_ay_q;
  logic [15:0]   a_mt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (pipe_en) begin
      a_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_adx_q   <= adx;
      a_ady_q   <= ady;
      a_dxneg_q <= dx[VW];
      a_dyneg_q <= dy[VW];
      a_ax_q    <= s_axis_tdata[95:64];
      a_ay_q    <= s_axis_tdata[127:96];
      a_mt_q    <= s_axis_tdata[143:128];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: squares of the offsets, |strength| * dt
  // ---------------------------------------------------------------------------
  logic [VW-1:0]    ms;
  logic [VW+15:0]   amul;
  logic [2*MW-1:0]  sx, sy;

  assign ms   = strength_q[VW-1] ? VW'(-strength_q) : strength_q;
  assign amul = ms * a_mt_q;
  assign sx   = a_adx_q * a_adx_q;
  assign sy   = a_ady_q * a_ady_q;

  logic            b_vld_q;
  logic [2*MW-1:0] b_sx_q, b_sy_q;
  logic [AW-1:0]   b_a_q;
  logic [MW-1:0]   b_adx_q, b_ady_q;
  logic            b_dxneg_q, b_dyneg_q;
  logic [VW-1:0]   b_ax_q, b_ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (pipe_en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      b_sx_q    <= sx;
      b_sy_q    <= sy;
      b_a_q     <= amul[pau_pkg::TimeFrac +: AW];
      b_adx_q   <= a_adx_q;
      b_ady_q   <= a_ady_q;
      b_dxneg_q <= a_dxneg_q;
      b_dyneg_q <= a_dyneg_q;
      b_ax_q    <= a_ax_q;
      b_ay_q    <= a_ay_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: S = dx^2 + dy^2, exact
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [MW-1:0]            adx;
    logic [MW-1:0]            ady;
    logic                     dxneg;
    logic                     dyneg;
    logic [VW-1:0]            ax;
    logic [VW-1:0]            ay;
    logic [AW-1:0]            a;
    logic [pau_pkg::SqW-1:0]  s;
  } sq_side_t;

  logic     c_vld_q;
  sq_side_t c_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (pipe_en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      c_side_q.adx   <= b_adx_q;
      c_side_q.ady   <= b_ady_q;
      c_side_q.dxneg <= b_dxneg_q;
      c_side_q.dyneg <= b_dyneg_q;
      c_side_q.ax    <= b_ax_q;
      c_side_q.ay    <= b_ay_q;
      c_side_q.a     <= b_a_q;
      c_side_q.s     <= {1'b0, b_sx_q} + {1'b0, b_sy_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Distance r = floor(sqrt(S))
  // ---------------------------------------------------------------------------
  logic          sq_vld;
  logic [RW-1:0] sq_root;
  sq_side_t      sq_side;

  pau_isqrt #(
    .ROOT_W (RW),
    .SIDE_W ($bits(sq_side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (c_vld_q),
    .x_i     ((2*RW)'(c_side_q.s)),
    .side_i  (c_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // ---------------------------------------------------------------------------
  // Stage D: clamp r and S/ONE to one, pick multiply operand and divisor
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [RW-1:0] r;
    logic [AW-1:0] a;
    logic [MW-1:0] adx;
    logic [MW-1:0] ady;
    logic          dxneg;
    logic          dyneg;
    logic [VW-1:0] ax;
    logic [VW-1:0] ay;
  } geo_t;

  logic [RW-1:0] dist_m;
  logic [QW-1:0] sq_hi, dist_q;

  assign dist_m = (sq_root < OneR) ? OneR : sq_root;
  assign sq_hi  = sq_side.s[pau_pkg::SqW-1:FB];
  assign dist_q = (sq_hi < OneQ) ? OneQ : sq_hi;

  logic          d_vld_q;
  logic [QW-1:0] d_op_q, d_den_q;
  geo_t          d_geo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (pipe_en) begin
      d_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      d_op_q  <= (falloff_q == pau_pkg::FallQuad) ? dist_q : QW'(dist_m);
      d_den_q <= (falloff_q == pau_pkg::FallInvQuad) ? dist_q : QW'(dist_m);
      d_geo_q <= '{r: sq_root, a: sq_side.a, adx: sq_side.adx, ady: sq_side.ady,
                   dxneg: sq_side.dxneg, dyneg: sq_side.dyneg,
                   ax: sq_side.ax, ay: sq_side.ay};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: a * operand as two partial products
  // ---------------------------------------------------------------------------
  logic [AW+31:0]  pl;
  logic [AW+HiW-1:0] ph;

  assign pl = d_geo_q.a * d_op_q[31:0];
  assign ph = d_geo_q.a * d_op_q[QW-1:32];

  logic              e_vld_q;
  logic [AW+31:0]    e_pl_q;
  logic [AW+HiW-1:0] e_ph_q;
  logic [QW-1:0]     e_den_q;
  geo_t              e_geo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (pipe_en) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      e_pl_q  <= pl;
      e_ph_q  <= ph;
      e_den_q <= d_den_q;
      e_geo_q <= d_geo_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: combine partial products, drop the fraction
  // ---------------------------------------------------------------------------
  logic [pau_pkg::ProdW-1:0] pm;

  assign pm = pau_pkg::ProdW'(e_pl_q) + {e_ph_q, 32'b0};

  typedef struct packed {
    logic [PW-1:0] pmul;
    geo_t          geo;
  } dv_side_t;

  logic          f_vld_q;
  logic [QW-1:0] f_den_q;
  dv_side_t      f_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (pipe_en) begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      f_den_q       <= e_den_q;
      f_side_q.pmul <= pm[pau_pkg::ProdW-1:FB];
      f_side_q.geo  <= e_geo_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Inverse falloff: a * ONE / max(1, r) or / max(1, S)
  // ---------------------------------------------------------------------------
  logic                          dv_vld;
  logic [pau_pkg::DivNumW-1:0]   dv_quo;
  dv_side_t                      dv_side;

  pau_div #(
    .NUM_W  (pau_pkg::DivNumW),
    .DEN_W  (QW),
    .SIDE_W ($bits(dv_side_t))
  ) u_div_fall (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (f_vld_q),
    .num_i   ({f_side_q.geo.a, FB'(0)}),
    .den_i   (f_den_q),
    .rem_i   ('0),
    .side_i  (f_side_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // ---------------------------------------------------------------------------
  // Stage G: pull magnitude p by falloff mode (undefined modes act constant)
  // ---------------------------------------------------------------------------
  logic [PW-1:0] pull;

  always_comb begin
    case (falloff_q)
      pau_pkg::FallLinear,
      pau_pkg::FallQuad:    pull = dv_side.pmul;
      pau_pkg::FallInvLin,
      pau_pkg::FallInvQuad: pull = PW'(dv_quo);
      default:              pull = PW'(dv_side.geo.a);
    endcase
  end

  logic          g_vld_q;
  logic [PW-1:0] g_p_q;
  geo_t          g_geo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (pipe_en) begin
      g_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      g_p_q   <= pull;
      g_geo_q <= dv_side.geo;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage H: p * |dx| and p * |dy| as partial products
  // ---------------------------------------------------------------------------
  logic [63:0] hxl, hxh, hyl, hyh;

  assign hxl = g_p_q[31:0]  * g_geo_q.adx;
  assign hxh = g_p_q[63:32] * g_geo_q.adx;
  assign hyl = g_p_q[31:0]  * g_geo_q.ady;
  assign hyh = g_p_q[63:32] * g_geo_q.ady;

  logic          h_vld_q;
  logic [63:0]   h_xl_q, h_xh_q, h_yl_q, h_yh_q;
  logic [31:0]   h_plo_q;
  logic          h_phnz_q;
  geo_t          h_geo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else if (pipe_en) begin
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      h_xl_q   <= hxl;
      h_xh_q   <= hxh;
      h_yl_q   <= hyl;
      h_yh_q   <= hyh;
      h_plo_q  <= g_p_q[31:0];
      h_phnz_q <= |g_p_q[63:32];
      h_geo_q  <= g_geo_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage I: full products; a quotient of 2^32 or more saturates any sum,
  // so flag it and divide only the low 32 quotient bits.
  // ---------------------------------------------------------------------------
  logic [95:0] nx, ny;
  logic [63:0] hix, hiy;
  logic        r_zero;

  assign nx     = {h_xh_q, 32'b0} + {32'b0, h_xl_q};
  assign ny     = {h_yh_q, 32'b0} + {32'b0, h_yl_q};
  assign hix    = nx[95:32];
  assign hiy    = ny[95:32];
  assign r_zero = (h_geo_q.r == '0);

  typedef struct packed {
    logic          satx;
    logic          rzero;
    logic [31:0]   plo;
    logic          dxneg;
    logic          dyneg;
    logic [VW-1:0] ax;
    logic [VW-1:0] ay;
  } fin_t;

  logic          i_vld_q;
  logic [RW-1:0] i_remx_q, i_remy_q, i_r_q;
  logic [31:0]   i_lowx_q, i_lowy_q;
  logic          i_saty_q;
  fin_t          i_fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_vld_q <= 1'b0;
    end else if (pipe_en) begin
      i_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      i_remx_q      <= hix[RW-1:0];
      i_remy_q      <= hiy[RW-1:0];
      i_lowx_q      <= nx[31:0];
      i_lowy_q      <= ny[31:0];
      i_r_q         <= h_geo_q.r;
      i_saty_q      <= hiy >= 64'(h_geo_q.r);
      // on the point the pull goes along +x unscaled
      i_fin_q.satx  <= r_zero ? h_phnz_q : (hix >= 64'(h_geo_q.r));
      i_fin_q.rzero <= r_zero;
      i_fin_q.plo   <= h_plo_q;
      i_fin_q.dxneg <= h_geo_q.dxneg;
      i_fin_q.dyneg <= h_geo_q.dyneg;
      i_fin_q.ax    <= h_geo_q.ax;
      i_fin_q.ay    <= h_geo_q.ay;
    end
  end

  // ---------------------------------------------------------------------------
  // Direction: p*|dx|/r and p*|dy|/r, low 32 quotient bits
  // ---------------------------------------------------------------------------
  logic        qx_vld, qy_vld;
  logic [31:0] quo_x, quo_y;
  fin_t        qx_fin;
  logic        qy_sat;

  pau_div #(
    .NUM_W  (32),
    .DEN_W  (RW),
    .SIDE_W ($bits(fin_t))
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (i_vld_q),
    .num_i   (i_lowx_q),
    .den_i   (i_r_q),
    .rem_i   (i_remx_q),
    .side_i  (i_fin_q),
    .valid_o (qx_vld),
    .quo_o   (quo_x),
    .side_o  (qx_fin)
  );

  pau_div #(
    .NUM_W  (32),
    .DEN_W  (RW),
    .SIDE_W (1)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (i_vld_q),
    .num_i   (i_lowy_q),
    .den_i   (i_r_q),
    .rem_i   (i_remy_q),
    .side_i  (i_saty_q),
    .valid_o (qy_vld),
    .quo_o   (quo_y),
    .side_o  (qy_sat)
  );

  // ---------------------------------------------------------------------------
  // Output stage: signed saturating add onto the attribute
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] sat_add(logic [31:0] attr, logic [32:0] mag, logic neg);
    logic signed [33:0] ext;
    logic signed [33:0] sum;
    ext = {{2{attr[31]}}, attr};
    sum = neg ? (ext - $signed({1'b0, mag})) : (ext + $signed({1'b0, mag}));
    if (sum > 34'sh0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (sum < -34'sh0_8000_0000) begin
      return 32'h8000_0000;
    end
    return sum[31:0];
  endfunction

  localparam logic [32:0] SatMag = 33'h1_0000_0000;

  logic [32:0] magx, magy;
  logic        sneg;
  logic [31:0] new_x, new_y;
  logic        applied;

  assign sneg    = strength_q[VW-1];
  assign applied = (strength_q != '0);
  assign magx    = qx_fin.satx ? SatMag
                 : {1'b0, (qx_fin.rzero ? qx_fin.plo : quo_x)};
  assign magy    = qx_fin.rzero ? '0 : (qy_sat ? SatMag : {1'b0, quo_y});
  assign new_x   = applied ? sat_add(qx_fin.ax, magx, sneg ^ qx_fin.dxneg) : qx_fin.ax;
  assign new_y   = applied ? sat_add(qx_fin.ay, magy, sneg ^ qx_fin.dyneg) : qx_fin.ay;

  logic [pau_pkg::OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      out_vld_q <= qx_vld && qy_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_data_q <= {7'b0, applied, new_y, new_x};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PAU_ASSERT_IMPL(a_applied_flag, m_axis_tvalid, m_axis_tdata[64] == (strength_q != '0), "applied flag disagrees with strength")
  `PAU_ASSERT(a_stall_holds_entry, !s_axis_tready |=> $stable(a_vld_q), "first stage moved during a stall")
  `PAU_ASSERT_IMPL(a_lanes_aligned, qx_vld != qy_vld, 1'b0, "x and y direction dividers out of step")

endmodule

[rtl/pau_isqrt.sv]
// Pipelined integer square root, one root bit per stage, with a side band.
// Depends on nothing.
`timescale 1ns / 1ps
module pau_isqrt #(
  parameter int unsigned ROOT_W = 33,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2*ROOT_W-1:0]   x_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [SIDE_W-1:0]     side_o
);

  logic                  vld_q  [ROOT_W];
  logic [ROOT_W+1:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0]     root_q [ROOT_W];
  logic [2*ROOT_W-1:0]   x_q    [ROOT_W];
  logic [SIDE_W-1:0]     side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic                vld_in;
    logic [ROOT_W+1:0]   rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] x_in;
    logic [SIDE_W-1:0]   side_in;
    logic [ROOT_W+3:0]   rem4;
    logic [ROOT_W+3:0]   trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down two bits, try 4*root+1
    assign rem4  = {rem_in, x_in[2*ROOT_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = rem4 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (ROOT_W+2)'(rem4 - trial) : rem4[ROOT_W+1:0];
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        x_q[k]    <= {x_in[2*ROOT_W-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

[rtl/pau_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a side band.
// Depends on nothing; rem_i must be below den_i for an exact quotient.
`timescale 1ns / 1ps
module pau_div #(
  parameter int unsigned NUM_W  = 47,
  parameter int unsigned DEN_W  = 49,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [NUM_W];
  logic [NUM_W-1:0]  num_q  [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic              vld_in;
    logic [NUM_W-1:0]  num_in;
    logic [DEN_W-1:0]  den_in;
    logic [DEN_W-1:0]  rem_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign rem_in  = rem_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign num_in  = num_q[k-1];
      assign den_in  = den_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    // dividend bits shift out on top while quotient bits shift in below
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k]  <= {num_in[NUM_W-2:0], ge};
        rem_q[k]  <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o   = num_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule
